FILE: rtl/udec_pkg.sv
// shared types and constants for the strict utf-8 decoder
// depends on nothing; imported by every rtl file of the block
package udec_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [20:0] CP_MIN2   = 21'h000080;
  localparam logic [20:0] CP_MIN3   = 21'h000800;
  localparam logic [20:0] CP_MIN4   = 21'h010000;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;

  typedef enum logic [2:0] {
    KIND_ASCII,
    KIND_CONT,
    KIND_LEAD2,
    KIND_LEAD3,
    KIND_LEAD4,
    KIND_INVALID
  } udec_kind_t;

  typedef struct packed {
    udec_kind_t kind;
    logic [6:0] payload;
    logic       last;
  } udec_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  rune_bytes;
    logic        rune_error;
    logic        buffer_end;
    logic        buffer_valid;
  } udec_result_t;

endpackage

FILE: rtl/udec_front.sv
// front end: classifies each input byte and strips its marker bits
// depends on udec_pkg
module udec_front import udec_pkg::*; (
  input  logic [7:0] data_byte,
  input  logic       last_in_buffer,
  output udec_item_t item
);

  always_comb begin
    item.last    = last_in_buffer;
    item.payload = 7'd0;
    item.kind    = KIND_INVALID;
    if (data_byte[7] == 1'b0) begin
      item.kind    = KIND_ASCII;
      item.payload = data_byte[6:0];
    end else if (data_byte[7:6] == 2'b10) begin
      item.kind    = KIND_CONT;
      item.payload = {1'b0, data_byte[5:0]};
    end else if (data_byte[7:5] == 3'b110) begin
      item.kind    = KIND_LEAD2;
      item.payload = {2'b0, data_byte[4:0]};
    end else if (data_byte[7:4] == 4'b1110) begin
      item.kind    = KIND_LEAD3;
      item.payload = {3'b0, data_byte[3:0]};
    end else if (data_byte[7:3] == 5'b11110) begin
      item.kind    = KIND_LEAD4;
      item.payload = {4'b0, data_byte[2:0]};
    end
  end

endmodule

FILE: rtl/udec_queue.sv
// short queue of classified beats between front and back
// depends on udec_pkg
module udec_queue import udec_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  udec_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output udec_item_t pop_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  udec_item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/udec_back.sv
// back end: sequence state, range checks and the output register
// depends on udec_pkg
module udec_back import udec_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_ready,
  input  udec_item_t   item,
  output logic         res_valid,
  input  logic         res_ready,
  output udec_result_t res
);

  logic [1:0]   needed;
  logic [1:0]   needed_next;
  logic [2:0]   seq_len;
  logic [2:0]   seq_len_next;
  logic [20:0]  partial;
  logic [20:0]  partial_next;
  logic         error_seen;
  logic         error_seen_next;
  logic         emit;
  logic         err;
  logic [20:0]  cp;
  logic [2:0]   len;
  logic [20:0]  merged;
  logic [20:0]  min_cp;
  logic         pop;
  udec_result_t res_next;

  assign pop        = item_valid && (!res_valid || res_ready);
  assign item_ready = !res_valid || res_ready;
  assign merged     = {partial[14:0], item.payload[5:0]};

  always_comb begin
    case (seq_len)
      3'd2:    min_cp = CP_MIN2;
      3'd3:    min_cp = CP_MIN3;
      default: min_cp = CP_MIN4;
    endcase
  end

  always_comb begin
    needed_next     = needed;
    seq_len_next    = seq_len;
    partial_next    = partial;
    error_seen_next = error_seen;
    emit            = 1'b0;
    err             = 1'b0;
    cp              = 21'd0;
    len             = 3'd0;
    if (pop) begin
      if (needed == 2'd0) begin
        case (item.kind)
          KIND_ASCII: begin
            emit = 1'b1;
            cp   = {14'd0, item.payload};
            len  = 3'd1;
          end
          KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
            partial_next = {14'd0, item.payload};
            if (item.kind == KIND_LEAD2) begin
              seq_len_next = 3'd2;
              needed_next  = 2'd1;
            end else if (item.kind == KIND_LEAD3) begin
              seq_len_next = 3'd3;
              needed_next  = 2'd2;
            end else begin
              seq_len_next = 3'd4;
              needed_next  = 2'd3;
            end
            if (item.last) begin
              needed_next = 2'd0;
              emit        = 1'b1;
              err         = 1'b1;
            end
          end
          default: begin
            emit = 1'b1;
            err  = 1'b1;
          end
        endcase
      end else if (item.kind != KIND_CONT) begin
        needed_next = 2'd0;
        emit        = 1'b1;
        err         = 1'b1;
      end else begin
        partial_next = merged;
        needed_next  = needed - 2'd1;
        if (needed == 2'd1) begin
          emit = 1'b1;
          cp   = merged;
          len  = seq_len;
          err  = (merged < min_cp) || ((merged >= SURR_LO) && (merged <= SURR_HI)) ||
                 (merged > CP_MAX);
        end else if (item.last) begin
          needed_next = 2'd0;
          emit        = 1'b1;
          err         = 1'b1;
        end
      end
      if (emit) begin
        if (item.last) begin
          error_seen_next = 1'b0;
        end else if (err) begin
          error_seen_next = 1'b1;
        end
      end
    end
    res_next.code_point   = err ? 21'd0 : cp;
    res_next.rune_bytes   = err ? 3'd0 : len;
    res_next.rune_error   = err;
    res_next.buffer_end   = item.last;
    res_next.buffer_valid = item.last && !err && !error_seen;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needed     <= 2'd0;
      seq_len    <= 3'd0;
      partial    <= 21'd0;
      error_seen <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      needed     <= needed_next;
      seq_len    <= seq_len_next;
      partial    <= partial_next;
      error_seen <= error_seen_next;
      if (pop) begin
        res_valid <= emit;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/utf8_validating_decoder_core.sv
// top level of the strict utf-8 decoder: front classifier, queue, back decoder
// depends on udec_pkg, udec_front, udec_queue, udec_back
//
// Takes one byte per beat and returns at most one result per byte: a code point when a
// sequence completes, an error result for malformed, overlong, surrogate, out-of-range or
// truncated input, and a result for every byte marked last_in_buffer, which carries
// buffer_end and the sticky buffer_valid flag. Sustained rate is one byte per cycle while
// out_ready is held high; an accepted byte is written into the queue, then decoded from the
// queue head into the output register, where its result, if any, waits until out_ready takes
// it. in_ready drops only while the QUEUE_DEPTH-entry queue is full, which happens when
// out_ready is held low.
module utf8_validating_decoder_core import udec_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_in_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_point,
  output logic [2:0]  rune_bytes,
  output logic        rune_error,
  output logic        buffer_end,
  output logic        buffer_valid
);

  udec_item_t   front_item;
  udec_item_t   q_item;
  logic         q_valid;
  logic         q_ready;
  udec_result_t res;

  udec_front u_front (
    .data_byte      (data_byte),
    .last_in_buffer (last_in_buffer),
    .item           (front_item)
  );

  udec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  udec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign code_point   = res.code_point;
  assign rune_bytes   = res.rune_bytes;
  assign rune_error   = res.rune_error;
  assign buffer_end   = res.buffer_end;
  assign buffer_valid = res.buffer_valid;

endmodule

FILE: rtl/udec_checker.sv
// port-level checks for the strict utf-8 decoder, bound to the top level
// depends on udec_pkg and utf8_validating_decoder_core
module udec_checker import udec_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic [2:0]  rune_bytes,
  input logic        rune_error,
  input logic        buffer_end,
  input logic        buffer_valid
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(rune_bytes)
      && $stable(rune_error) && $stable(buffer_end) && $stable(buffer_valid))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && rune_error |-> code_point == 21'd0 && rune_bytes == 3'd0 && !buffer_valid)
    else $error("error result carries data");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !buffer_end |-> !buffer_valid)
    else $error("buffer_valid outside buffer end");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !rune_error |-> rune_bytes != 3'd0 && rune_bytes <= 3'd4
      && code_point <= CP_MAX && (rune_bytes != 3'd1 || code_point < CP_MIN2))
    else $error("good rune out of range");

endmodule

bind utf8_validating_decoder_core udec_checker u_udec_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .code_point   (code_point),
  .rune_bytes   (rune_bytes),
  .rune_error   (rune_error),
  .buffer_end   (buffer_end),
  .buffer_valid (buffer_valid)
);

FILE: tb/utf8_rune_checker.sv
// checker for the strict utf-8 decoder: predicts the result of every byte beat
// and compares each result beat against the oldest prediction; depends on udec_pkg
`timescale 1ns / 1ps

module utf8_rune_checker import udec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_in_buffer,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [20:0] code_point,
  input  logic [2:0]  rune_bytes,
  input  logic        rune_error,
  input  logic        buffer_end,
  input  logic        buffer_valid,
  output int          mismatches,
  output int          pending,
  output int          results_seen,
  output int          bad_runes,
  output int          buffers_closed
);

  logic [1:0]  need;
  logic [2:0]  seq_len;
  logic [20:0] partial;
  logic        err_seen;

  udec_result_t expected_runes[$];
  udec_result_t next_rune;
  udec_result_t want;
  bit           hit;

  task automatic return_to_idle();
    need    = 2'd0;
    seq_len = 3'd0;
    partial = 21'd0;
  endtask

  task automatic predict_rune(input logic [7:0] b, input logic last,
                              output bit emitted, output udec_result_t r);
    logic [20:0] cp;
    logic [20:0] floor_cp;
    logic [2:0]  len;
    bit          bad;
    emitted = 1'b0;
    bad     = 1'b0;
    cp      = 21'd0;
    len     = 3'd0;
    r       = '0;
    if (need == 2'd0) begin
      if (b < 8'h80) begin
        emitted = 1'b1;
        cp      = {13'd0, b};
        len     = 3'd1;
      end else if (b < 8'hC0 || b >= 8'hF8) begin
        emitted = 1'b1;
        bad     = 1'b1;
      end else begin
        if (b < 8'hE0) begin
          seq_len = 3'd2;
          partial = {16'd0, b[4:0]};
        end else if (b < 8'hF0) begin
          seq_len = 3'd3;
          partial = {17'd0, b[3:0]};
        end else begin
          seq_len = 3'd4;
          partial = {18'd0, b[2:0]};
        end
        need = seq_len[1:0] - 2'd1;
        if (last) begin
          emitted = 1'b1;
          bad     = 1'b1;
          return_to_idle();
        end
      end
    end else if (b[7:6] != 2'b10) begin
      emitted = 1'b1;
      bad     = 1'b1;
      return_to_idle();
    end else begin
      partial = {partial[14:0], b[5:0]};
      need    = need - 2'd1;
      if (need == 2'd0) begin
        emitted  = 1'b1;
        cp       = partial;
        len      = seq_len;
        floor_cp = (len == 3'd2) ? CP_MIN2 : (len == 3'd3) ? CP_MIN3 : CP_MIN4;
        bad      = (cp < floor_cp) || (cp >= SURR_LO && cp <= SURR_HI) || (cp > CP_MAX);
        return_to_idle();
      end else if (last) begin
        emitted = 1'b1;
        bad     = 1'b1;
        return_to_idle();
      end
    end
    if (emitted) begin
      r.code_point   = bad ? 21'd0 : cp;
      r.rune_bytes   = bad ? 3'd0 : len;
      r.rune_error   = bad;
      r.buffer_end   = last;
      r.buffer_valid = last && !bad && !err_seen;
      if (bad) err_seen = 1'b1;
      if (last) err_seen = 1'b0;
    end
  endtask

  function automatic int field_diff(string name, logic [20:0] exp_v, logic [20:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      return_to_idle();
      err_seen = 1'b0;
      expected_runes.delete();
      mismatches     = 0;
      results_seen   = 0;
      bad_runes      = 0;
      buffers_closed = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_rune(data_byte, last_in_buffer, hit, next_rune);
        if (hit) expected_runes.push_back(next_rune);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_runes.size() == 0) begin
          $error("result beat arrived with nothing expected");
          mismatches++;
        end else begin
          want = expected_runes.pop_front();
          if (want.rune_error) bad_runes++;
          if (want.buffer_end) buffers_closed++;
          mismatches += field_diff("code_point", want.code_point, code_point);
          mismatches += field_diff("rune_bytes", want.rune_bytes, rune_bytes);
          mismatches += field_diff("rune_error", want.rune_error, rune_error);
          mismatches += field_diff("buffer_end", want.buffer_end, buffer_end);
          mismatches += field_diff("buffer_valid", want.buffer_valid, buffer_valid);
        end
      end
    end
    pending = expected_runes.size();
  end

endmodule

FILE: tb/utf8_validating_decoder_core_test.sv
// top of the strict utf-8 decoder testbench: clock, reset, byte stimulus, verdict
// depends on udec_pkg, utf8_validating_decoder_core and utf8_rune_checker
`timescale 1ns / 1ps

module utf8_validating_decoder_core_test import udec_pkg::*;;

  localparam int BYTE_TARGET = 1450;
  localparam int CALM_FROM   = 1300;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_in_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [20:0] code_point;
  logic [2:0]  rune_bytes;
  logic        rune_error;
  logic        buffer_end;
  logic        buffer_valid;

  int mismatches;
  int pending;
  int results_seen;
  int bad_runes;
  int buffers_closed;

  int bytes_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  logic [8:0] tx_q[$];

  utf8_validating_decoder_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last_in_buffer(last_in_buffer),
    .out_valid(out_valid), .out_ready(out_ready),
    .code_point(code_point), .rune_bytes(rune_bytes), .rune_error(rune_error),
    .buffer_end(buffer_end), .buffer_valid(buffer_valid)
  );

  utf8_rune_checker rune_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last_in_buffer(last_in_buffer),
    .out_valid(out_valid), .out_ready(out_ready),
    .code_point(code_point), .rune_bytes(rune_bytes), .rune_error(rune_error),
    .buffer_end(buffer_end), .buffer_valid(buffer_valid),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen),
    .bad_runes(bad_runes), .buffers_closed(buffers_closed)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic logic [31:0] encode(logic [20:0] cp, int len);
    case (len)
      1:       return {25'd0, cp[6:0]};
      2:       return {16'd0, 3'b110, cp[10:6], 2'b10, cp[5:0]};
      3:       return {8'd0, 4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
      default: return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
    endcase
  endfunction

  function automatic logic [20:0] pick_cp(int len);
    logic [20:0] lo;
    logic [20:0] hi;
    logic [20:0] cp;
    int          r;
    lo = (len == 1) ? 21'h0 : (len == 2) ? CP_MIN2 : (len == 3) ? CP_MIN3 : CP_MIN4;
    hi = (len == 1) ? 21'h7F : (len == 2) ? 21'h7FF : (len == 3) ? 21'hFFFF : CP_MAX;
    r  = $urandom_range(0, 7);
    if (r == 0) cp = lo;
    else if (r == 1) cp = hi;
    else if (r == 2 && len == 3) cp = $urandom_range(0, 1) ? 21'hD7FF : 21'hE000;
    else cp = 21'($urandom_range(hi, lo));
    if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h004000;
    return cp;
  endfunction

  task automatic add_word(input logic [31:0] w, input int n, input bit last);
    logic tag;
    for (int i = n - 1; i >= 0; i--) begin
      tag = (last && i == 0) ? 1'b1 : 1'b0;
      tx_q.push_back({tag, w[i*8 +: 8]});
    end
  endtask

  task automatic add_random_rune();
    int          pick;
    int          len;
    int          k;
    logic [20:0] cp;
    logic [20:0] floor_cp;
    logic [31:0] w;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(1, 4);
    if (pick < 45) begin
      add_word(encode(pick_cp(len), len), len, 1'b0);
    end else if (pick < 55) begin
      // overlong forms
      len      = $urandom_range(2, 4);
      floor_cp = (len == 2) ? CP_MIN2 : (len == 3) ? CP_MIN3 : CP_MIN4;
      cp       = ($urandom_range(0, 3) == 0) ? floor_cp - 21'd1
                                             : 21'($urandom_range(floor_cp - 21'd1, 0));
      add_word(encode(cp, len), len, 1'b0);
    end else if (pick < 62) begin
      cp = 21'($urandom_range(SURR_HI, SURR_LO));
      add_word(encode(cp, 3), 3, 1'b0);
    end else if (pick < 69) begin
      cp = ($urandom_range(0, 3) == 0) ? CP_MAX + 21'd1
                                       : 21'($urandom_range(21'h1FFFFF, CP_MAX + 21'd1));
      add_word(encode(cp, 4), 4, 1'b0);
    end else if (pick < 76) begin
      b = 8'($urandom_range(8'hBF, 8'h80));
      add_word({24'd0, b}, 1, 1'b0);
    end else if (pick < 82) begin
      b = 8'($urandom_range(8'hFF, 8'hF8));
      add_word({24'd0, b}, 1, 1'b0);
    end else if (pick < 92) begin
      // sequence broken by a byte that is not a continuation
      len = $urandom_range(2, 4);
      k   = $urandom_range(1, len - 1);
      w   = encode(pick_cp(len), len) >> (8 * (len - 1 - k));
      b   = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      w[7:0] = b;
      add_word(w, k + 1, 1'b0);
    end else begin
      b = 8'($urandom_range(0, 255));
      add_word({24'd0, b}, 1, 1'b0);
    end
  endtask

  task automatic build_buffer();
    int runes;
    int len;
    int k;
    runes = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
    repeat (runes) add_random_rune();
    if ($urandom_range(0, 5) == 0) begin
      // buffer ends inside a sequence
      len = $urandom_range(2, 4);
      k   = $urandom_range(1, len - 1);
      add_word(encode(pick_cp(len), len) >> (8 * (len - k)), k, 1'b0);
    end
    tx_q[tx_q.size() - 1][8] = 1'b1;
  endtask

  task automatic send_beat(input logic [8:0] beat);
    bit took;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= beat[7:0];
    last_in_buffer <= beat[8];
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (tx_q.size() > 0) send_beat(tx_q.pop_front());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ascii extremes, two-byte extremes, overlong, stray, invalid lead
    add_word(32'h0000007F, 2, 1'b0);
    add_word(32'h0000C280, 2, 1'b0);
    add_word(32'h0000DFBF, 2, 1'b0);
    add_word(32'h0000C080, 2, 1'b0);
    add_word(32'h00000080, 1, 1'b0);
    add_word(32'h000000FF, 1, 1'b0);
    // three-byte minimum, surrogate, four-byte maximum, above range
    add_word(32'h00E0A080, 3, 1'b0);
    add_word(32'h00EDA080, 3, 1'b0);
    add_word(32'hF48FBFBF, 4, 1'b0);
    add_word(32'hF4908080, 4, 1'b0);
    // bad continuation, then truncated at buffer end, then a clean buffer
    add_word(32'h0000C341, 2, 1'b0);
    add_word(32'h0000E282, 2, 1'b1);
    add_word(32'h00000041, 1, 1'b1);
    send_queued();
    drain_results();

    while (bytes_sent < BYTE_TARGET) begin
      if (bytes_sent >= CALM_FROM || $urandom_range(0, 3) == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(10, 40);
        stall_pct = $urandom_range(10, 40);
      end
      build_buffer();
      send_queued();
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    drain_results();
    repeat (32) @(posedge clk);
    $display("covered %0d bytes in %0d buffers, %0d results checked, %0d rune errors",
             bytes_sent, buffers_closed, results_seen, bad_runes);
    $display("directed edge cases plus random valid, malformed and cut-short streams");
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/udec_pkg.sv
rtl/udec_front.sv
rtl/udec_queue.sv
rtl/udec_back.sv
rtl/utf8_validating_decoder_core.sv
rtl/udec_checker.sv
tb/utf8_rune_checker.sv
tb/utf8_validating_decoder_core_test.sv
